>>> hw/rtl/lpba_pkg.sv
// shared widths, types and codes of the lidar point box assigner
package lpba_pkg;

   // field widths
   localparam int SLOT_W     = 4;
   localparam int COORD_W    = 13;
   localparam int DIM_W      = 12;
   localparam int PT_W       = 16;
   localparam int PIX_W      = 16;
   localparam int COUNT_W    = 5;
   localparam int COEF_W     = 32;
   localparam int CSR_W      = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int SHRINK_W   = 8;

   // projection arithmetic
   localparam int PROD_W       = COEF_W + PT_W;
   localparam int SUM_W        = 50;
   localparam int MAG_W        = SUM_W;
   localparam int QUO_W        = PIX_W - 1;
   localparam int PT_ONE_SHIFT = 8;

   // box shrink arithmetic
   localparam int SHRINK_ONE = 1 << SHRINK_W;
   localparam int POS_SHIFT  = SHRINK_W + 1;
   localparam int POS_SUM_W  = COORD_W + POS_SHIFT + 1;
   localparam int POS_W      = POS_SUM_W - POS_SHIFT;
   localparam int LEN_W      = DIM_W + 1;
   localparam int CMP_W      = PIX_W + 2;

   localparam int MAX_BOXES_DEF = 16;
   localparam int COUNT_MAX     = (1 << COUNT_W) - 1;

   localparam logic [SHRINK_W-1:0]     SHRINK_RESET = SHRINK_W'(26);
   localparam logic signed [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
   localparam logic signed [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW0_LO = 3'd0,
      CSR_ROW0_HI = 3'd1,
      CSR_ROW1_LO = 3'd2,
      CSR_ROW1_HI = 3'd3,
      CSR_ROW2_LO = 3'd4,
      CSR_ROW2_HI = 3'd5,
      CSR_SHRINK  = 3'd6
   } csr_index_type;

   // beat kinds
   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_POINT = 1'b1
   } req_kind_type;

   typedef logic [2:0][3:0][COEF_W-1:0] matrix_type;

   typedef struct packed {
      logic                      valid;
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic [DIM_W-1:0]          width;
      logic [DIM_W-1:0]          height;
   } box_type;

   // what a beat carries down the pipe besides the math
   typedef struct packed {
      logic              is_point;
      logic [SLOT_W-1:0] slot;
      box_type           box;
   } carry_type;

   // divider state for both pixel coordinates
   typedef struct packed {
      logic             neg_u;
      logic             neg_v;
      logic             ovf_u;
      logic             ovf_v;
      logic             zero;
      logic [MAG_W-1:0] den;
      logic [MAG_W-1:0] rem_u;
      logic [MAG_W-1:0] rem_v;
      logic [QUO_W-1:0] q_u;
      logic [QUO_W-1:0] q_v;
   } div_type;

   typedef struct packed {
      logic                    zero;
      logic signed [PIX_W-1:0] u;
      logic signed [PIX_W-1:0] v;
   } pix_type;

   typedef struct packed {
      logic                    assigned;
      logic [SLOT_W-1:0]       assigned_box;
      logic [COUNT_W-1:0]      enclosing_count;
      logic signed [PIX_W-1:0] pixel_u;
      logic signed [PIX_W-1:0] pixel_v;
      logic                    depth_zero;
   } rsp_type;

endpackage

>>> hw/rtl/lpba_if.sv
// request and response channel interfaces
interface lpba_req_if import lpba_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [SLOT_W-1:0]         box_slot;
   logic                      box_valid;
   logic signed [COORD_W-1:0] box_left;
   logic signed [COORD_W-1:0] box_top;
   logic [DIM_W-1:0]          box_width;
   logic [DIM_W-1:0]          box_height;
   logic signed [PT_W-1:0]    point_x;
   logic signed [PT_W-1:0]    point_y;
   logic signed [PT_W-1:0]    point_z;

   modport source (output valid, req_type, box_slot, box_valid, box_left, box_top,
                   box_width, box_height, point_x, point_y, point_z, input ready);
   modport sink (input valid, req_type, box_slot, box_valid, box_left, box_top,
                 box_width, box_height, point_x, point_y, point_z, output ready);
endinterface

interface lpba_rsp_if import lpba_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    assigned;
   logic [SLOT_W-1:0]       assigned_box;
   logic [COUNT_W-1:0]      enclosing_count;
   logic signed [PIX_W-1:0] pixel_u;
   logic signed [PIX_W-1:0] pixel_v;
   logic                    depth_zero;

   modport source (output valid, assigned, assigned_box, enclosing_count, pixel_u,
                   pixel_v, depth_zero, input ready);
   modport sink (input valid, assigned, assigned_box, enclosing_count, pixel_u,
                 pixel_v, depth_zero, output ready);
endinterface

>>> hw/rtl/lidar_point_box_assigner.sv
// Lidar point box assigner. Load beats write one entry of a table of up to MAX_BOXES
// image boxes; point beats are projected through a 3x4 fixed-point camera matrix,
// divided by depth (truncated toward zero, saturated to 16 bits) and tested against
// every valid box shrunk by the shrink fraction, assigned when exactly one box holds
// the pixel. The pipeline takes one beat per cycle while no result is held, and a point
// passes 3 stages of multiply, row sum and magnitude, 15 divider stages of one
// quotient bit each, a saturation stage, and 3 stages of box geometry, containment and
// counting. Load beats occupy a slot and give no result; the table is written when a
// load passes the box stage, so each point sees every earlier load.
// The whole pipeline holds while a result waits in the output register.
module lidar_point_box_assigner import lpba_pkg::*; #(
   parameter int MAX_BOXES = MAX_BOXES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   lpba_req_if.sink             req,
   lpba_rsp_if.source           rsp,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   matrix_type          coef_ff;
   logic [SHRINK_W-1:0] shrink_ff;
   logic                adv;
   carry_type           req_carry;
   logic                p_vld;
   carry_type           p_carry;
   div_type             p_div;
   logic                d_vld;
   carry_type           d_carry;
   pix_type             d_pix;
   logic                o_vld;
   rsp_type             o_rsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff   <= '0;
         shrink_ff <= SHRINK_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROW0_LO: begin
               coef_ff[0][0] <= csr_wdata[CSR_W-1:COEF_W];
               coef_ff[0][1] <= csr_wdata[COEF_W-1:0];
            end
            CSR_ROW0_HI: begin
               coef_ff[0][2] <= csr_wdata[CSR_W-1:COEF_W];
               coef_ff[0][3] <= csr_wdata[COEF_W-1:0];
            end
            CSR_ROW1_LO: begin
               coef_ff[1][0] <= csr_wdata[CSR_W-1:COEF_W];
               coef_ff[1][1] <= csr_wdata[COEF_W-1:0];
            end
            CSR_ROW1_HI: begin
               coef_ff[1][2] <= csr_wdata[CSR_W-1:COEF_W];
               coef_ff[1][3] <= csr_wdata[COEF_W-1:0];
            end
            CSR_ROW2_LO: begin
               coef_ff[2][0] <= csr_wdata[CSR_W-1:COEF_W];
               coef_ff[2][1] <= csr_wdata[COEF_W-1:0];
            end
            CSR_ROW2_HI: begin
               coef_ff[2][2] <= csr_wdata[CSR_W-1:COEF_W];
               coef_ff[2][3] <= csr_wdata[COEF_W-1:0];
            end
            CSR_SHRINK: begin
               shrink_ff <= csr_wdata[SHRINK_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // pipeline advances unless a result is held
   assign adv       = !o_vld || rsp.ready;
   assign req.ready = adv;

   assign req_carry.is_point   = (req.req_type == REQ_POINT);
   assign req_carry.slot       = req.box_slot;
   assign req_carry.box.valid  = req.box_valid;
   assign req_carry.box.left   = req.box_left;
   assign req_carry.box.top    = req.box_top;
   assign req_carry.box.width  = req.box_width;
   assign req_carry.box.height = req.box_height;

   lpba_proj u_proj (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_vld    (req.valid),
      .in_carry  (req_carry),
      .in_x      (req.point_x),
      .in_y      (req.point_y),
      .in_z      (req.point_z),
      .coef      (coef_ff),
      .out_vld   (p_vld),
      .out_carry (p_carry),
      .out_div   (p_div)
   );

   lpba_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_vld    (p_vld),
      .in_carry  (p_carry),
      .in_div    (p_div),
      .out_vld   (d_vld),
      .out_carry (d_carry),
      .out_pix   (d_pix)
   );

   lpba_boxes #(.MAX_BOXES(MAX_BOXES)) u_boxes (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (d_vld),
      .in_carry (d_carry),
      .in_pix   (d_pix),
      .shrink   (shrink_ff),
      .out_vld  (o_vld),
      .out_rsp  (o_rsp)
   );

   // response beat
   assign rsp.valid           = o_vld;
   assign rsp.assigned        = o_rsp.assigned;
   assign rsp.assigned_box    = o_rsp.assigned_box;
   assign rsp.enclosing_count = o_rsp.enclosing_count;
   assign rsp.pixel_u         = o_rsp.pixel_u;
   assign rsp.pixel_v         = o_rsp.pixel_v;
   assign rsp.depth_zero      = o_rsp.depth_zero;

endmodule

>>> hw/rtl/lpba_proj.sv
// projection front end: products, row sums, magnitudes and overflow check
module lpba_proj import lpba_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_vld,
   input  carry_type              in_carry,
   input  logic signed [PT_W-1:0] in_x,
   input  logic signed [PT_W-1:0] in_y,
   input  logic signed [PT_W-1:0] in_z,
   input  matrix_type             coef,
   output logic                   out_vld,
   output carry_type              out_carry,
   output div_type                out_div
);

   logic signed [PT_W-1:0]   pt [3];
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [SUM_W-1:0]  bias_ff [3];
   logic signed [SUM_W-1:0]  sum_ff [3];
   logic                     vld_ff [3];
   carry_type                car_ff [3];
   div_type                  div_in;
   div_type                  div_ff;
   logic [MAG_W-1:0]         mag [3];

   assign pt[0] = in_x;
   assign pt[1] = in_y;
   assign pt[2] = in_z;

   // valid bits of the three stages
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
         vld_ff[1] <= 1'b0;
         vld_ff[2] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_vld;
         vld_ff[1] <= vld_ff[0];
         vld_ff[2] <= vld_ff[1];
      end
   end

   // stage 1: coefficient times coordinate, homogeneous term as a shift
   always_ff @(posedge clock) begin
      if (adv) begin
         car_ff[0] <= in_carry;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= $signed(coef[r][c]) * pt[c];
            end
            bias_ff[r] <= {{(SUM_W-COEF_W-PT_ONE_SHIFT){coef[r][3][COEF_W-1]}},
                           coef[r][3], {PT_ONE_SHIFT{1'b0}}};
         end
      end
   end

   // stage 2: row sums
   always_ff @(posedge clock) begin
      if (adv) begin
         car_ff[1] <= car_ff[0];
         for (int r = 0; r < 3; r++) begin
            sum_ff[r] <= SUM_W'(prod_ff[r][0]) + SUM_W'(prod_ff[r][1])
                       + SUM_W'(prod_ff[r][2]) + bias_ff[r];
         end
      end
   end

   // stage 3: signs, magnitudes and quotient overflow
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         mag[r] = sum_ff[r][SUM_W-1] ? MAG_W'(-sum_ff[r]) : MAG_W'(sum_ff[r]);
      end
      div_in.neg_u = sum_ff[0][SUM_W-1] ^ sum_ff[2][SUM_W-1];
      div_in.neg_v = sum_ff[1][SUM_W-1] ^ sum_ff[2][SUM_W-1];
      div_in.ovf_u = (MAG_W+QUO_W)'(mag[0]) >= {mag[2], {QUO_W{1'b0}}};
      div_in.ovf_v = (MAG_W+QUO_W)'(mag[1]) >= {mag[2], {QUO_W{1'b0}}};
      div_in.zero  = (sum_ff[2] == '0);
      div_in.den   = mag[2];
      div_in.rem_u = mag[0];
      div_in.rem_v = mag[1];
      div_in.q_u   = '0;
      div_in.q_v   = '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         car_ff[2] <= car_ff[1];
         div_ff    <= div_in;
      end
   end

   assign out_vld   = vld_ff[2];
   assign out_carry = car_ff[2];
   assign out_div   = div_ff;

endmodule

>>> hw/rtl/lpba_div.sv
// pipelined restoring divider, one quotient bit per stage, then saturation
module lpba_div import lpba_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      adv,
   input  logic      in_vld,
   input  carry_type in_carry,
   input  div_type   in_div,
   output logic      out_vld,
   output carry_type out_carry,
   output pix_type   out_pix
);

   logic      vld_src [QUO_W];
   carry_type car_src [QUO_W];
   div_type   div_src [QUO_W];
   logic      vld_ff  [QUO_W];
   carry_type car_ff  [QUO_W];
   div_type   div_ff  [QUO_W];
   logic      vld_o_ff;
   carry_type car_o_ff;
   pix_type   pix_o_ff;
   pix_type   pix_in;
   div_type   last;

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      localparam int B = QUO_W - 1 - k;
      div_type                  nxt;
      logic [MAG_W+QUO_W-1:0] den_sh;

      // stage input
      if (k == 0) begin : g_first
         assign vld_src[k] = in_vld;
         assign car_src[k] = in_carry;
         assign div_src[k] = in_div;
      end else begin : g_next
         assign vld_src[k] = vld_ff[k-1];
         assign car_src[k] = car_ff[k-1];
         assign div_src[k] = div_ff[k-1];
      end

      // trial subtract of the shifted divisor for both quotients
      always_comb begin
         nxt    = div_src[k];
         den_sh = (MAG_W+QUO_W)'(div_src[k].den) << B;
         if ((MAG_W+QUO_W)'(div_src[k].rem_u) >= den_sh) begin
            nxt.rem_u  = div_src[k].rem_u - den_sh[MAG_W-1:0];
            nxt.q_u[B] = 1'b1;
         end
         if ((MAG_W+QUO_W)'(div_src[k].rem_v) >= den_sh) begin
            nxt.rem_v  = div_src[k].rem_v - den_sh[MAG_W-1:0];
            nxt.q_v[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_src[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            car_ff[k] <= car_src[k];
            div_ff[k] <= nxt;
         end
      end
   end

   function automatic logic signed [PIX_W-1:0] sat_pix(logic neg, logic ovf,
                                                      logic [QUO_W-1:0] q);
      logic signed [PIX_W-1:0] mag;
      mag = signed'({1'b0, q});
      if (ovf) begin
         return neg ? PIX_MIN : PIX_MAX;
      end
      return neg ? -mag : mag;
   endfunction

   // sign and saturation of the quotients
   assign last = div_ff[QUO_W-1];
   always_comb begin
      pix_in.zero = last.zero;
      pix_in.u    = sat_pix(last.neg_u, last.ovf_u, last.q_u);
      pix_in.v    = sat_pix(last.neg_v, last.ovf_v, last.q_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_o_ff <= 1'b0;
      end else if (adv) begin
         vld_o_ff <= vld_ff[QUO_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         car_o_ff <= car_ff[QUO_W-1];
         pix_o_ff <= pix_in;
      end
   end

   assign out_vld   = vld_o_ff;
   assign out_carry = car_o_ff;
   assign out_pix   = pix_o_ff;

endmodule

>>> hw/rtl/lpba_boxes.sv
// box table, shrunk box lanes, containment test and result register
module lpba_boxes import lpba_pkg::*; #(
   parameter int MAX_BOXES = MAX_BOXES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_vld,
   input  carry_type           in_carry,
   input  pix_type             in_pix,
   input  logic [SHRINK_W-1:0] shrink,
   output logic                out_vld,
   output rsp_type             out_rsp
);

   localparam int IDX_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CNT_W = $clog2(MAX_BOXES + 1);

   box_type                   tbl_ff [MAX_BOXES];
   logic                      slot_ok;
   logic [IDX_W-1:0]          slot_idx;

   logic                      a_vld_ff;
   logic                      a_point_ff;
   pix_type                   a_pix_ff;
   logic                      a_en_ff [MAX_BOXES];
   logic signed [POS_W-1:0]   a_bx_ff [MAX_BOXES];
   logic signed [POS_W-1:0]   a_by_ff [MAX_BOXES];
   logic [LEN_W-1:0]          a_bw_ff [MAX_BOXES];
   logic [LEN_W-1:0]          a_bh_ff [MAX_BOXES];

   logic                      b_vld_ff;
   logic                      b_point_ff;
   pix_type                   b_pix_ff;
   logic [MAX_BOXES-1:0]      b_hit_ff;

   logic                      o_vld_ff;
   rsp_type                   o_rsp_ff;
   rsp_type                   rsp_in;
   logic [CNT_W-1:0]          cnt;
   logic [SLOT_W-1:0]         found;

   // shrunk corner: trunc((512*pos + s*len) / 512)
   function automatic logic signed [POS_W-1:0] shrink_pos(
         logic signed [COORD_W-1:0] pos, logic [DIM_W-1:0] len,
         logic [SHRINK_W-1:0] s);
      logic signed [POS_SUM_W-1:0] acc;
      logic signed [POS_SUM_W-1:0] adj;
      acc = (POS_SUM_W'(pos) <<< POS_SHIFT) + signed'(POS_SUM_W'(s * len));
      adj = acc + signed'({{(POS_SUM_W-POS_SHIFT){1'b0}}, {POS_SHIFT{acc[POS_SUM_W-1]}}});
      return adj[POS_SUM_W-1:POS_SHIFT];
   endfunction

   // shrunk length: floor(len * (256 - s) / 256)
   function automatic logic [LEN_W-1:0] shrink_len(logic [DIM_W-1:0] len,
                                                    logic [SHRINK_W-1:0] s);
      logic [SHRINK_W:0]         keep;
      logic [DIM_W+SHRINK_W:0]   prod;
      keep = (SHRINK_W+1)'(SHRINK_ONE) - {1'b0, s};
      prod = len * keep;
      return prod[DIM_W+SHRINK_W:SHRINK_W];
   endfunction

   // table writes by load beats, in pipeline order
   assign slot_ok  = int'(in_carry.slot) < MAX_BOXES;
   assign slot_idx = IDX_W'(in_carry.slot);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_BOXES; i++) begin
            tbl_ff[i].valid <= 1'b0;
         end
      end else if (adv && in_vld && !in_carry.is_point && slot_ok) begin
         tbl_ff[slot_idx] <= in_carry.box;
      end
   end

   // lane stage: shrunk geometry of every entry
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= in_vld;
         b_vld_ff <= a_vld_ff;
         o_vld_ff <= b_vld_ff && b_point_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_point_ff <= in_carry.is_point;
         a_pix_ff   <= in_pix;
         for (int i = 0; i < MAX_BOXES; i++) begin
            a_en_ff[i] <= tbl_ff[i].valid;
            a_bx_ff[i] <= shrink_pos(tbl_ff[i].left, tbl_ff[i].width, shrink);
            a_by_ff[i] <= shrink_pos(tbl_ff[i].top, tbl_ff[i].height, shrink);
            a_bw_ff[i] <= shrink_len(tbl_ff[i].width, shrink);
            a_bh_ff[i] <= shrink_len(tbl_ff[i].height, shrink);
         end
      end
   end

   // hit stage: half-open containment per lane
   always_ff @(posedge clock) begin
      if (adv) begin
         b_point_ff <= a_point_ff;
         b_pix_ff   <= a_pix_ff;
         for (int i = 0; i < MAX_BOXES; i++) begin
            b_hit_ff[i] <= a_en_ff[i]
               && (CMP_W'(a_pix_ff.u) >= CMP_W'(a_bx_ff[i]))
               && (CMP_W'(a_pix_ff.u) < CMP_W'(a_bx_ff[i]) + signed'(CMP_W'(a_bw_ff[i])))
               && (CMP_W'(a_pix_ff.v) >= CMP_W'(a_by_ff[i]))
               && (CMP_W'(a_pix_ff.v) < CMP_W'(a_by_ff[i]) + signed'(CMP_W'(a_bh_ff[i])));
         end
      end
   end

   // count and last hit, then the result beat
   always_comb begin
      cnt   = '0;
      found = '0;
      for (int i = 0; i < MAX_BOXES; i++) begin
         cnt = cnt + CNT_W'(b_hit_ff[i]);
         if (b_hit_ff[i]) begin
            found = SLOT_W'(i);
         end
      end
      rsp_in.depth_zero      = b_pix_ff.zero;
      rsp_in.assigned        = !b_pix_ff.zero && (int'(cnt) == 1);
      rsp_in.assigned_box    = rsp_in.assigned ? found : '0;
      rsp_in.enclosing_count = b_pix_ff.zero ? '0
                             : (int'(cnt) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                             : COUNT_W'(cnt);
      rsp_in.pixel_u         = b_pix_ff.zero ? '0 : b_pix_ff.u;
      rsp_in.pixel_v         = b_pix_ff.zero ? '0 : b_pix_ff.v;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_rsp_ff <= rsp_in;
      end
   end

   assign out_vld = o_vld_ff;
   assign out_rsp = o_rsp_ff;

endmodule

>>> hw/rtl/lpba_checker.sv
// port-level checks of the lidar point box assigner and their binding
module lpba_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                rsp_assigned,
   input logic [3:0]          rsp_assigned_box,
   input logic [4:0]          rsp_enclosing_count,
   input logic signed [15:0]  rsp_pixel_u,
   input logic signed [15:0]  rsp_pixel_v,
   input logic                rsp_depth_zero
);

   // held response beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_assigned, rsp_assigned_box,
         rsp_enclosing_count, rsp_pixel_u, rsp_pixel_v, rsp_depth_zero}))
      else $error("response changed while stalled");

   // intake never blocks while the output register is free
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   // zero depth gives an all-zero result
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_depth_zero |-> !rsp_assigned && rsp_enclosing_count == 5'd0
         && rsp_pixel_u == 16'sd0 && rsp_pixel_v == 16'sd0)
      else $error("zero depth with nonzero result");

   // assignment only with a single enclosing box
   a_assign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_assigned |-> rsp_enclosing_count == 5'd1)
      else $error("assigned without a single enclosing box");

   // slot is zero when not assigned
   a_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_assigned |-> rsp_assigned_box == 4'd0)
      else $error("slot set on unassigned point");

endmodule

bind lidar_point_box_assigner lpba_checker u_lpba_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req.ready),
   .rsp_valid           (rsp.valid),
   .rsp_ready           (rsp.ready),
   .rsp_assigned        (rsp.assigned),
   .rsp_assigned_box    (rsp.assigned_box),
   .rsp_enclosing_count (rsp.enclosing_count),
   .rsp_pixel_u         (rsp.pixel_u),
   .rsp_pixel_v         (rsp.pixel_v),
   .rsp_depth_zero      (rsp.depth_zero)
);

>>> dv/tb.sv
// self-checking testbench of the lidar point box assigner
module tb;
   import lpba_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 40;

   typedef struct {
      req_kind_type              kind;
      logic [SLOT_W-1:0]         slot;
      logic                      bvalid;
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic [DIM_W-1:0]          width;
      logic [DIM_W-1:0]          height;
      logic signed [PT_W-1:0]    px;
      logic signed [PT_W-1:0]    py;
      logic signed [PT_W-1:0]    pz;
   } beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0] csr_wdata = '0;

   lpba_req_if req ();
   lpba_rsp_if rsp ();

   lidar_point_box_assigner u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic signed [COEF_W-1:0] coef [3][4];
   logic [SHRINK_W-1:0] shrink;
   box_type boxes [MAX_BOXES_DEF];
   rsp_type pixel_q [$];

   bit quiet = 0;
   int errors = 0;
   int stall_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req.valid = 1'b0;
      req.req_type = REQ_LOAD;
      req.box_slot = '0;
      req.box_valid = 1'b0;
      req.box_left = '0;
      req.box_top = '0;
      req.box_width = '0;
      req.box_height = '0;
      req.point_x = '0;
      req.point_y = '0;
      req.point_z = '0;
      rsp.ready = 1'b0;
   end

   // projection, division and box count of one point
   function automatic rsp_type project_point(beat_type b);
      rsp_type r;
      longint y [3];
      longint u, v, s, bx, by, bw, bh;
      int cnt, hit;
      r = '0;
      for (int i = 0; i < 3; i++)
         y[i] = longint'(coef[i][0]) * longint'(b.px) + longint'(coef[i][1]) * longint'(b.py)
              + longint'(coef[i][2]) * longint'(b.pz) + longint'(coef[i][3]) * 256;
      if (y[2] == 0) begin
         r.depth_zero = 1'b1;
         return r;
      end
      u = y[0] / y[2];
      v = y[1] / y[2];
      if (u > 32767) u = 32767;
      if (u < -32768) u = -32768;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      s = longint'(shrink);
      cnt = 0;
      hit = 0;
      for (int i = 0; i < MAX_BOXES_DEF; i++) begin
         if (!boxes[i].valid) continue;
         bx = (longint'(boxes[i].left) * 512 + s * longint'(boxes[i].width)) / 512;
         by = (longint'(boxes[i].top) * 512 + s * longint'(boxes[i].height)) / 512;
         bw = (longint'(boxes[i].width) * (256 - s)) / 256;
         bh = (longint'(boxes[i].height) * (256 - s)) / 256;
         if (u >= bx && u < bx + bw && v >= by && v < by + bh) begin
            if (cnt < COUNT_MAX) cnt++;
            hit = i;
         end
      end
      if (cnt == 1) begin
         r.assigned = 1'b1;
         r.assigned_box = SLOT_W'(hit);
      end
      r.enclosing_count = COUNT_W'(cnt);
      r.pixel_u = PIX_W'(u);
      r.pixel_v = PIX_W'(v);
      return r;
   endfunction

   // response side: random stall bursts and in-order compare
   always @(posedge clock) begin
      rsp_type e;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            if (pixel_q.size() == 0) begin
               $error("response beat with nothing expected");
               errors++;
            end else begin
               e = pixel_q.pop_front();
               if (rsp.assigned !== e.assigned) begin
                  $error("assigned exp %0d got %0d", e.assigned, rsp.assigned); errors++;
               end
               if (rsp.assigned_box !== e.assigned_box) begin
                  $error("assigned_box exp %0d got %0d", e.assigned_box, rsp.assigned_box);
                  errors++;
               end
               if (rsp.enclosing_count !== e.enclosing_count) begin
                  $error("enclosing_count exp %0d got %0d", e.enclosing_count,
                         rsp.enclosing_count);
                  errors++;
               end
               if (rsp.pixel_u !== e.pixel_u) begin
                  $error("pixel_u exp %0d got %0d", e.pixel_u, rsp.pixel_u); errors++;
               end
               if (rsp.pixel_v !== e.pixel_v) begin
                  $error("pixel_v exp %0d got %0d", e.pixel_v, rsp.pixel_v); errors++;
               end
               if (rsp.depth_zero !== e.depth_zero) begin
                  $error("depth_zero exp %0d got %0d", e.depth_zero, rsp.depth_zero);
                  errors++;
               end
            end
         end
      end
      if (quiet) begin
         rsp.ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp.ready <= 1'b0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 15);
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= 1'b1;
      end
   end

   // send one beat, update the predictor on acceptance
   task automatic send_beat(beat_type b);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.req_type <= b.kind;
      req.box_slot <= b.slot;
      req.box_valid <= b.bvalid;
      req.box_left <= b.left;
      req.box_top <= b.top;
      req.box_width <= b.width;
      req.box_height <= b.height;
      req.point_x <= b.px;
      req.point_y <= b.py;
      req.point_z <= b.pz;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      if (b.kind == REQ_POINT) begin
         pixel_q = {pixel_q, project_point(b)};
      end else begin
         boxes[b.slot] = '{valid: b.bvalid, left: b.left, top: b.top,
                           width: b.width, height: b.height};
      end
   endtask

   // stop sending and let the pipe empty
   task automatic drain;
      req.valid <= 1'b0;
      @(posedge clock);
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write the whole register set, plus one unused index
   task automatic program_regs(logic signed [COEF_W-1:0] m [3][4], logic [SHRINK_W-1:0] sh);
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         if (i < 6) csr_wdata <= {m[i/2][(i%2)*2], m[i/2][(i%2)*2+1]};
         else if (i == CSR_SHRINK) csr_wdata <= {$urandom, 24'h0, sh};
         else csr_wdata <= {$urandom, $urandom};
         @(posedge clock);
      end
      csr_we <= 1'b0;
      coef = m;
      shrink = sh;
   endtask

   function automatic beat_type load_beat(int slot, bit bv, int l, int t, int w, int h);
      beat_type b;
      b = '{kind: REQ_LOAD, slot: SLOT_W'(slot), bvalid: bv, left: COORD_W'(l),
            top: COORD_W'(t), width: DIM_W'(w), height: DIM_W'(h),
            px: PT_W'($urandom), py: PT_W'($urandom), pz: PT_W'($urandom)};
      return b;
   endfunction

   function automatic beat_type point_beat(int x, int y, int z);
      beat_type b;
      b = '{kind: REQ_POINT, slot: SLOT_W'($urandom), bvalid: 1'($urandom),
            left: COORD_W'($urandom), top: COORD_W'($urandom), width: DIM_W'($urandom),
            height: DIM_W'($urandom), px: PT_W'(x), py: PT_W'(y), pz: PT_W'(z)};
      return b;
   endfunction

   function automatic beat_type random_beat();
      beat_type b;
      b = '{kind: req_kind_type'(1'($urandom)), slot: SLOT_W'($urandom),
            bvalid: 1'($urandom),
            left: COORD_W'($urandom), top: COORD_W'($urandom), width: DIM_W'($urandom),
            height: DIM_W'($urandom), px: PT_W'($urandom), py: PT_W'($urandom),
            pz: PT_W'($urandom)};
      return b;
   endfunction

   // pixel is 256*x/depth and 256*y/depth, so x and y for depth 256; depth chosen by caller
   task automatic program_identity(int depth, logic [SHRINK_W-1:0] sh);
      logic signed [COEF_W-1:0] m [3][4];
      m = '{default: '{default: '0}};
      m[0][0] = 32'sh0001_0000;
      m[1][1] = 32'sh0001_0000;
      m[2][3] = COEF_W'(depth);
      program_regs(m, sh);
   endtask

   // reset registers: zero matrix means zero depth on every point
   task automatic test_zero_depth;
      send_beat(point_beat(32767, -32768, 0));
      send_beat(point_beat(-32768, 32767, -1));
      send_beat(point_beat(0, 0, 32767));
      drain();
   endtask

   // directed box geometry: edges, clear, empty box, extremes
   task automatic test_box_edges;
      program_identity(256, 8'd0);
      send_beat(load_beat(0, 1, 10, 20, 30, 40));
      send_beat(load_beat(15, 1, -4096, -4096, 4095, 4095));
      send_beat(load_beat(3, 1, 4095, 4095, 0, 0));
      send_beat(point_beat(10, 20, 5));
      send_beat(point_beat(39, 59, 5));
      send_beat(point_beat(40, 20, 5));
      send_beat(point_beat(4095, 4095, 0));
      send_beat(point_beat(-4096, -4096, 0));
      send_beat(point_beat(-4097, 0, 0));
      send_beat(load_beat(15, 0, 0, 0, 0, 0));
      send_beat(point_beat(15, 25, 0));
      send_beat(point_beat(-100, -100, 0));
      drain();
      program_identity(256, 8'd255);
      send_beat(point_beat(39, 59, 0));
      send_beat(point_beat(10, 20, 0));
      send_beat(load_beat(1, 1, -20, -20, 4095, 4095));
      send_beat(point_beat(4070, 4070, 0));
      send_beat(point_beat(-5, -5, 0));
      drain();
      program_identity(-256, 8'd26);
      send_beat(point_beat(-12, -25, 0));
      send_beat(point_beat(-20, -30, 0));
      drain();
   endtask

   // huge rows 0 and 1 against tiny depth saturate the pixel both ways
   task automatic test_saturation;
      logic signed [COEF_W-1:0] m [3][4];
      m = '{default: '{default: '0}};
      m[0][0] = 32'sh7fff_ffff;
      m[1][1] = 32'sh8000_0000;
      m[2][3] = 32'sh0000_0001;
      program_regs(m, 8'd26);
      send_beat(point_beat(32767, 32767, 0));
      send_beat(point_beat(-32768, -32768, 0));
      send_beat(point_beat(1, -1, 0));
      drain();
   endtask

   // random matrices (small coefficients in one phase) and full random beats
   task automatic test_random_matrix;
      logic signed [COEF_W-1:0] m [3][4];
      for (int ph = 0; ph < 3; ph++) begin
         foreach (m[r, c]) m[r][c] = COEF_W'($urandom);
         if (ph == 1) begin
            // small coefficients keep pixels near the boxes
            foreach (m[r, c]) m[r][c] = COEF_W'($signed($urandom_range(0, 2047)) - 1024);
         end
         program_regs(m, 8'($urandom));
         repeat (100) send_beat(random_beat());
         drain();
      end
   endtask

   // identity projection, random boxes, points mostly aimed into boxes
   task automatic test_random_boxes;
      int j, bx, by, bw, bh, s;
      for (int ph = 0; ph < 4; ph++) begin
         program_identity(256, 8'($urandom));
         for (int k = 0; k < 195; k++) begin
            if (ph == 3 && k == 60) quiet = 1;
            if (ph == 1 && k == 80) begin
               req.valid <= 1'b0;
               @(posedge clock);
               while (pixel_q.size() != 0) @(posedge clock);
            end
            if ($urandom_range(0, 3) == 0) begin
               send_beat(load_beat($urandom_range(0, 15), $urandom_range(0, 7) != 0,
                                   $signed($urandom_range(0, 600)) - 300,
                                   $signed($urandom_range(0, 600)) - 300,
                                   $urandom_range(0, 200), $urandom_range(0, 200)));
            end else if ($urandom_range(0, 9) == 0) begin
               send_beat(point_beat($urandom, $urandom, $urandom));
            end else begin
               j = $urandom_range(0, 15);
               s = shrink;
               bx = (boxes[j].left * 512 + s * int'(boxes[j].width)) / 512;
               by = (boxes[j].top * 512 + s * int'(boxes[j].height)) / 512;
               bw = (int'(boxes[j].width) * (256 - s)) / 256;
               bh = (int'(boxes[j].height) * (256 - s)) / 256;
               send_beat(point_beat(bx + $urandom_range(0, bw + 1) - 1,
                                    by + $urandom_range(0, bh + 1) - 1, $urandom));
            end
         end
         drain();
      end
   endtask

   initial begin
      coef = '{default: '{default: '0}};
      shrink = SHRINK_RESET;
      foreach (boxes[i]) boxes[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_zero_depth();
      test_box_edges();
      test_saturation();
      test_random_matrix();
      test_random_boxes();
      if (errors == 0 && pixel_q.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/lpba_pkg.sv
hw/rtl/lpba_if.sv
hw/rtl/lpba_proj.sv
hw/rtl/lpba_div.sv
hw/rtl/lpba_boxes.sv
hw/rtl/lidar_point_box_assigner.sv
hw/rtl/lpba_checker.sv
dv/tb.sv
